// ===== src/tnfs_pkg.sv =====
package tnfs_pkg;

    localparam int KEY_W     = 20;
    localparam int COUNT_W   = 24;
    localparam int STAMP_W   = 32;
    localparam int TOPC_W    = 5;
    localparam int TDATA_W   = 48;

    localparam logic [TOPC_W-1:0] TOPC_RESET = 5'd10;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [COUNT_W-1:0] count;
        logic [KEY_W-1:0]   key;
    } t_entry;

    typedef struct packed {
        logic take;
        logic append;
        logic scan_start;
        logic scan_run;
        logic replace;
        logic emit;
        logic emit_empty;
    } t_cmd;

    typedef struct packed {
        logic op_drain;
        logic room;
        logic empty;
        logic scan_done;
        logic out_free;
        logic emit_last;
    } t_sts;

endpackage

// ===== src/tnfs_ram.sv =====
module tnfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tnfs_dp.sv =====
module tnfs_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tnfs_pkg::TOPC_W-1:0]    i_cfg_wdata,
    input  logic                           i_op,
    input  logic [tnfs_pkg::KEY_W-1:0]     i_key,
    input  logic [tnfs_pkg::COUNT_W-1:0]   i_count,
    input  logic                           i_m_ready,
    output logic                           o_m_valid,
    output logic [tnfs_pkg::KEY_W-1:0]     o_m_key,
    output logic [tnfs_pkg::COUNT_W-1:0]   o_m_count,
    output logic                           o_m_last,
    output logic                           o_m_empty,
    input  tnfs_pkg::t_cmd                 i_cmd,
    output tnfs_pkg::t_sts                 o_sts
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = $bits(tnfs_pkg::t_entry);

    logic                             r_op;
    logic [tnfs_pkg::KEY_W-1:0]       r_key;
    logic [tnfs_pkg::COUNT_W-1:0]     r_count;
    logic [tnfs_pkg::TOPC_W-1:0]      r_top_count;
    logic [CW-1:0]                    r_total;
    logic [tnfs_pkg::STAMP_W-1:0]     r_arrival;
    logic [CW-1:0]                    r_raddr;
    logic                             r_pend;
    logic [AW-1:0]                    r_pidx;
    logic                             r_found;
    logic [AW-1:0]                    r_best_idx;
    logic [tnfs_pkg::KEY_W-1:0]       r_best_key;
    logic [tnfs_pkg::COUNT_W-1:0]     r_best_count;
    logic [tnfs_pkg::STAMP_W-1:0]     r_best_rank;
    logic [CAPACITY-1:0]              r_taken;
    logic [CW-1:0]                    r_emitted;
    logic                             r_o_valid;
    logic [tnfs_pkg::KEY_W-1:0]       r_o_key;
    logic [tnfs_pkg::COUNT_W-1:0]     r_o_count;
    logic                             r_o_last;
    logic                             r_o_empty;

    logic [CW-1:0]                    w_limit;
    logic                             w_issue;
    logic                             w_we;
    logic [AW-1:0]                    w_waddr;
    tnfs_pkg::t_entry                 w_wentry;
    logic [EW-1:0]                    w_rdata;
    tnfs_pkg::t_entry                 w_rentry;
    logic [tnfs_pkg::STAMP_W-1:0]     w_rank;
    logic                             w_drain;
    logic                             w_skip;
    logic                             w_better;
    logic                             w_update;
    logic                             w_out_free;
    logic                             w_emit_last;
    logic                             w_keep;

    always_comb begin
        if (r_top_count == '0) begin
            w_limit = CW'(1);
        end else if ({27'b0, r_top_count} > 32'(CAPACITY)) begin
            w_limit = CW'(CAPACITY);
        end else begin
            w_limit = CW'(r_top_count);
        end
    end

    assign w_drain  = (r_op == tnfs_pkg::OP_DRAIN);
    assign w_issue  = i_cmd.scan_run && (r_raddr < r_total);
    assign w_keep   = r_found && (r_count >= r_best_count);

    assign w_we     = i_cmd.append || (i_cmd.replace && w_keep);
    assign w_waddr  = i_cmd.append ? r_total[AW-1:0] : r_best_idx;
    assign w_wentry = '{stamp: r_arrival, count: r_count, key: r_key};

    tnfs_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_re    (w_issue),
        .i_raddr (r_raddr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rentry = tnfs_pkg::t_entry'(w_rdata);
    assign w_rank   = w_rentry.stamp - r_arrival;
    assign w_skip   = w_drain && r_taken[r_pidx];

    always_comb begin
        if (!r_found) begin
            w_better = 1'b1;
        end else if (w_drain) begin
            w_better = (w_rentry.count > r_best_count) ||
                       ((w_rentry.count == r_best_count) && (w_rank < r_best_rank));
        end else begin
            w_better = (w_rentry.count < r_best_count) ||
                       ((w_rentry.count == r_best_count) && (w_rank < r_best_rank));
        end
    end

    assign w_update    = i_cmd.scan_run && r_pend && !w_skip && w_better;
    assign w_out_free  = !r_o_valid || i_m_ready;
    assign w_emit_last = ((r_emitted + CW'(1)) == r_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_count <= tnfs_pkg::TOPC_RESET;
            r_total     <= '0;
            r_arrival   <= '0;
            r_raddr     <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_taken     <= '0;
            r_emitted   <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_top_count <= i_cfg_wdata;
            end

            if (i_cmd.take) begin
                r_op    <= i_op;
                r_key   <= i_key;
                r_count <= i_count;
            end

            if (i_cmd.append) begin
                r_total   <= r_total + CW'(1);
                r_arrival <= r_arrival + 1'b1;
            end

            if (i_cmd.replace && w_keep) begin
                r_arrival <= r_arrival + 1'b1;
            end

            if (i_cmd.scan_start) begin
                r_raddr <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else begin
                r_pend <= w_issue;
                if (w_issue) begin
                    r_raddr <= r_raddr + CW'(1);
                    r_pidx  <= r_raddr[AW-1:0];
                end
            end

            if (w_update) begin
                r_found      <= 1'b1;
                r_best_idx   <= r_pidx;
                r_best_key   <= w_rentry.key;
                r_best_count <= w_rentry.count;
                r_best_rank  <= w_rank;
            end

            if (i_cmd.emit || i_cmd.emit_empty) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_m_ready) begin
                r_o_valid <= 1'b0;
            end

            if (i_cmd.emit_empty) begin
                r_o_key   <= '0;
                r_o_count <= '0;
                r_o_last  <= 1'b0;
                r_o_empty <= 1'b1;
                r_arrival <= '0;
            end

            if (i_cmd.emit) begin
                r_o_key   <= r_best_key;
                r_o_count <= r_best_count;
                r_o_last  <= w_emit_last;
                r_o_empty <= 1'b0;
                if (w_emit_last) begin
                    r_total   <= '0;
                    r_arrival <= '0;
                    r_taken   <= '0;
                    r_emitted <= '0;
                end else begin
                    r_taken[r_best_idx] <= 1'b1;
                    r_emitted           <= r_emitted + CW'(1);
                end
            end
        end
    end

    assign o_sts = '{
        op_drain:  w_drain,
        room:      (r_total < w_limit),
        empty:     (r_total == '0),
        scan_done: (r_raddr >= r_total) && !r_pend,
        out_free:  w_out_free,
        emit_last: w_emit_last
    };

    assign o_m_valid = r_o_valid;
    assign o_m_key   = r_o_key;
    assign o_m_count = r_o_count;
    assign o_m_last  = r_o_last;
    assign o_m_empty = r_o_empty;

endmodule

// ===== src/tnfs_ctrl.sv =====
module tnfs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    output logic           o_s_ready,
    input  tnfs_pkg::t_sts i_sts,
    output tnfs_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!i_sts.op_drain) begin
                    if (i_sts.room) begin
                        o_cmd.append = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end else if (i_sts.empty) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_empty = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.op_drain) begin
                        n_state = ST_EMIT;
                    end else begin
                        o_cmd.replace = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);

endmodule

// ===== src/top_n_frequency_select_top.sv =====
// Offer with free room: the transaction is accepted, then appended to the store.
// Offer into a full store: one store entry read per cycle for the
// minimum search through the single read port of the entry memory.
// Drain of n kept entries: one full store scan per result; a drain of an empty store
// skips the scan. Results leave through an output register.
// Synchronous active-low reset: store empty, stamp zero, top_count 10, no result pending.
module top_n_frequency_select_top #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,        // top_count
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,     // entry_key[19:0], entry_count[43:20], zero pad
    input  logic        i_s_axis_tuser,     // op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,     // result_key[19:0], result_count[43:20], zero pad
    output logic        o_m_axis_tlast,     // result_last
    output logic        o_m_axis_tuser      // result_empty
);

    tnfs_pkg::t_cmd                   w_cmd;
    tnfs_pkg::t_sts                   w_sts;
    logic [tnfs_pkg::KEY_W-1:0]       w_m_key;
    logic [tnfs_pkg::COUNT_W-1:0]     w_m_count;

    tnfs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    tnfs_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (i_s_axis_tuser),
        .i_key       (i_s_axis_tdata[19:0]),
        .i_count     (i_s_axis_tdata[43:20]),
        .i_m_ready   (i_m_axis_tready),
        .o_m_valid   (o_m_axis_tvalid),
        .o_m_key     (w_m_key),
        .o_m_count   (w_m_count),
        .o_m_last    (o_m_axis_tlast),
        .o_m_empty   (o_m_axis_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    assign o_m_axis_tdata = {4'b0, w_m_count, w_m_key};

endmodule
